### hdl/mlpsgd_pkg.sv
// Shared constants, codes and a saturation helper for the perceptron
// with online learning. No dependencies; used by the top level.
`timescale 1ns / 1ps

package mlpsgd_pkg;

  // Network shape.
  localparam int INPUT_COUNT  = 16;
  localparam int HIDDEN_COUNT = 16;
  localparam int OUTPUT_COUNT = 16;

  localparam int I_W = $clog2(INPUT_COUNT);
  localparam int H_W = $clog2(HIDDEN_COUNT);
  localparam int O_W = $clog2(OUTPUT_COUNT);

  // Flat parameter map: hidden weights, hidden biases, output weights, output biases.
  localparam int ADDR_HB  = INPUT_COUNT * HIDDEN_COUNT;
  localparam int ADDR_OW  = ADDR_HB + HIDDEN_COUNT;
  localparam int ADDR_OB  = ADDR_OW + HIDDEN_COUNT * OUTPUT_COUNT;
  localparam int ADDR_END = ADDR_OB + OUTPUT_COUNT;
  localparam int PAR_AW   = $clog2(ADDR_END);

  // Field widths.
  localparam int REQ_W    = 2;
  localparam int WIDX_W   = 10;
  localparam int LABEL_W  = 4;
  localparam int SIDX_W   = 4;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Fixed point.
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  // Division by one thousand, sixteen bits per step: q = (x * DIV_RECIP) >> DIV_SHIFT
  // is exact for every x below 1000 * 2^16.
  localparam int          DIV_SHIFT = 36;
  localparam logic [26:0] DIV_RECIP = 27'd68719477;
  localparam logic [25:0] MILLI     = 26'd1000;
  localparam logic [47:0] HALF_MILLI = 48'd500;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE   = 2'd0,
    REQ_FEATURE = 2'd1,
    REQ_TRAIN   = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_e;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAD_CLIP  = 1'b1;

  localparam logic [CFG_W-1:0] LR_RESET   = 16'd10;
  localparam logic [CFG_W-1:0] CLIP_RESET = 16'd1000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### hdl/mlpsgd_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module mlpsgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 544
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### hdl/mlp_infer_and_sgd_update.sv
// Top level of the one-hidden-layer perceptron with inference and online learning.
// Depends on mlpsgd_pkg and the generic RAM mlpsgd_ram.
`timescale 1ns / 1ps

// How to use this block:
// The input channel (in_valid_i / in_stall_o) carries one request per transaction.
// A weight write stores one weight or bias at its flat address. A feature
// transaction stores the next input feature; the transaction that brings the
// last feature also starts the forward pass. The pass is paced by the single RAM
// port: every term of every dot product is one read, one multiply and one accumulate.
// The scores then leave on the output channel (out_valid_o / out_stall_i), one
// transaction per output neuron, with score_last_o on the final one. While the
// receiver stalls, the output register holds and the scores wait in place; the
// input side is open again as soon as the last score sits in the output register.
// A train transaction runs one gradient step: the clip bound division, one
// multiply-accumulate pass for the hidden gradient, and for each weight or bias
// updated a read, product, clamp, rate multiply, divide setup, three divide
// steps and a write. It gives no output.
// All weights and biases live in one RAM; every access is issued and completed
// before the next one starts, so reads never race writes to the same entry.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle, clears the
// feature count and the output valid, and restores the two configuration
// registers. Configuration writes are always taken (cfg_ready_o stays high).

module mlp_infer_and_sgd_update (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Request channel.
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [mlpsgd_pkg::REQ_W-1:0]           req_type_i,
  input  logic [mlpsgd_pkg::WIDX_W-1:0]          weight_index_i,
  input  logic signed [31:0]                     weight_value_i,
  input  logic signed [31:0]                     feature_value_i,
  input  logic [mlpsgd_pkg::LABEL_W-1:0]         label_i,
  // Score channel.
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [mlpsgd_pkg::SIDX_W-1:0]          score_index_o,
  output logic signed [31:0]                     score_value_o,
  output logic                                   score_last_o,
  // Configuration channel.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mlpsgd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mlpsgd_pkg::CFG_W-1:0]           cfg_data_i
);

  localparam int IW = mlpsgd_pkg::I_W;
  localparam int HW = mlpsgd_pkg::H_W;
  localparam int OW = mlpsgd_pkg::O_W;
  localparam int AW = mlpsgd_pkg::PAR_AW;

  // Sequencer states.
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_M_BRD   = 5'd1;
  localparam logic [4:0] S_M_BINIT = 5'd2;
  localparam logic [4:0] S_M_RD    = 5'd3;
  localparam logic [4:0] S_M_MUL   = 5'd4;
  localparam logic [4:0] S_M_ACC   = 5'd5;
  localparam logic [4:0] S_M_END   = 5'd6;
  localparam logic [4:0] S_EMIT    = 5'd7;
  localparam logic [4:0] S_T_CB    = 5'd8;
  localparam logic [4:0] S_DIV     = 5'd9;
  localparam logic [4:0] S_U_RD    = 5'd10;
  localparam logic [4:0] S_U_MUL   = 5'd11;
  localparam logic [4:0] S_U_CLAMP = 5'd12;
  localparam logic [4:0] S_U_LR    = 5'd13;
  localparam logic [4:0] S_U_DIVST = 5'd14;
  localparam logic [4:0] S_U_WR    = 5'd15;

  // Which pass the sequencer is running.
  localparam logic [2:0] K_FH = 3'd0;  // hidden layer forward
  localparam logic [2:0] K_FO = 3'd1;  // output layer forward
  localparam logic [2:0] K_HG = 3'd2;  // hidden gradient
  localparam logic [2:0] K_OW = 3'd3;  // output weight update
  localparam logic [2:0] K_OB = 3'd4;  // output bias update
  localparam logic [2:0] K_HW = 3'd5;  // hidden weight update
  localparam logic [2:0] K_HB = 3'd6;  // hidden bias update
  localparam logic [2:0] K_CB = 3'd7;  // clip bound division

  localparam logic [IW-1:0] I_LAST = IW'(mlpsgd_pkg::INPUT_COUNT - 1);
  localparam logic [HW-1:0] J_LAST = HW'(mlpsgd_pkg::HIDDEN_COUNT - 1);
  localparam logic [OW-1:0] K_LAST = OW'(mlpsgd_pkg::OUTPUT_COUNT - 1);

  logic [4:0]              state_q, state_d;
  logic [2:0]              kind_q, kind_d;
  logic [IW-1:0]           i_q, i_d;
  logic [HW-1:0]           j_q, j_d;
  logic [OW-1:0]           k_q, k_d;
  logic [IW-1:0]           feat_cnt_q, feat_cnt_d;
  logic [mlpsgd_pkg::LABEL_W-1:0] label_q, label_d;
  logic [mlpsgd_pkg::CFG_W-1:0]   lr_q, lr_d, clip_q, clip_d;
  logic [22:0]             cb_q, cb_d;
  logic signed [63:0]      acc_q, acc_d;
  logic signed [63:0]      prod_q, prod_d;
  logic signed [31:0]      w_q, w_d;
  logic signed [23:0]      g_q, g_d;
  logic signed [40:0]      p_q, p_d;
  logic                    neg_q, neg_d;
  logic [47:0]             div_num_q, div_num_d;
  logic [9:0]              div_rem_q, div_rem_d;
  logic [47:0]             div_quo_q, div_quo_d;
  logic [1:0]              div_cnt_q, div_cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [mlpsgd_pkg::SIDX_W-1:0] out_idx_q, out_idx_d;
  logic signed [31:0]      out_val_q, out_val_d;
  logic                    out_last_q, out_last_d;

  // Small per-neuron stores, each read at one counter-selected place.
  logic signed [31:0] feat_q  [mlpsgd_pkg::INPUT_COUNT];
  logic signed [31:0] act_q   [mlpsgd_pkg::HIDDEN_COUNT];
  logic signed [31:0] score_q [mlpsgd_pkg::OUTPUT_COUNT];
  logic signed [31:0] hg_q    [mlpsgd_pkg::HIDDEN_COUNT];

  logic               feat_we, act_we, score_we, hg_we;
  logic signed [31:0] store_wdata;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic signed [31:0] ram_wdata;
  logic [31:0]        ram_rdata;
  logic signed [31:0] ram_rd_s;

  logic in_acc, out_free, cfg_acc;

  // Operand views.
  logic signed [31:0] feat_rd, act_rd, score_rd, hg_rd, err_v;
  logic               onehot;
  logic [AW-1:0]      hw_addr, ow_addr, hb_addr, ob_addr, upd_addr;
  logic signed [31:0] upd_a, upd_b, mac_b;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p, rnd_v, cb_s;
  logic signed [31:0] sat_acc;
  logic               in_addr_ok;

  // Divider step.
  logic [25:0]        dx;
  logic [52:0]        dqm;
  logic [15:0]        dq16;
  logic [47:0]        dquo_next;
  logic signed [33:0] step_d;
  logic signed [63:0] new_w;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;

  assign in_stall_o    = (state_q != S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign score_index_o = out_idx_q;
  assign score_value_o = out_val_q;
  assign score_last_o  = out_last_q;

  assign ram_rd_s = $signed(ram_rdata);
  assign feat_rd  = feat_q[i_q];
  assign act_rd   = act_q[j_q];
  assign score_rd = score_q[k_q];
  assign hg_rd    = hg_q[j_q];

  // Error against the one-hot target; a label past the outputs never matches.
  assign onehot = (7'(k_q) == 7'(label_q));
  assign err_v  = mlpsgd_pkg::sat32(64'(score_rd) - (onehot ? 64'(mlpsgd_pkg::Q_ONE) : 64'sd0));

  assign hw_addr = AW'(int'(i_q) * mlpsgd_pkg::HIDDEN_COUNT + int'(j_q));
  assign ow_addr = AW'(mlpsgd_pkg::ADDR_OW + int'(j_q) * mlpsgd_pkg::OUTPUT_COUNT + int'(k_q));
  assign hb_addr = AW'(mlpsgd_pkg::ADDR_HB + int'(j_q));
  assign ob_addr = AW'(mlpsgd_pkg::ADDR_OB + int'(k_q));
  assign in_addr_ok = (32'(weight_index_i) < 32'(mlpsgd_pkg::ADDR_END));

  always_comb begin
    case (kind_q)
      K_OW: begin
        upd_addr = ow_addr;
        upd_a    = act_rd;
        upd_b    = err_v;
      end
      K_OB: begin
        upd_addr = ob_addr;
        upd_a    = err_v;
        upd_b    = mlpsgd_pkg::Q_ONE;
      end
      K_HW: begin
        upd_addr = hw_addr;
        upd_a    = feat_rd;
        upd_b    = hg_rd;
      end
      default: begin
        upd_addr = hb_addr;
        upd_a    = hg_rd;
        upd_b    = mlpsgd_pkg::Q_ONE;
      end
    endcase
  end

  always_comb begin
    case (kind_q)
      K_FH:    mac_b = feat_rd;
      K_FO:    mac_b = act_rd;
      default: mac_b = err_v;
    endcase
  end

  // One shared 32x32 multiplier for dot products and gradient products.
  always_comb begin
    if (state_q == S_U_MUL) begin
      mul_a = upd_a;
      mul_b = upd_b;
    end else begin
      mul_a = ram_rd_s;
      mul_b = mac_b;
    end
  end
  assign mul_p   = 64'(mul_a) * 64'(mul_b);
  assign rnd_v   = (prod_q + 64'sd32768) >>> 16;
  assign sat_acc = mlpsgd_pkg::sat32(acc_q);
  assign cb_s    = $signed({41'd0, cb_q});

  // Sixteen quotient bits per step of the divide by one thousand.
  assign dx        = {div_rem_q, div_num_q[47:32]};
  assign dqm       = 53'(dx) * 53'(mlpsgd_pkg::DIV_RECIP);
  assign dq16      = dqm[mlpsgd_pkg::DIV_SHIFT+15:mlpsgd_pkg::DIV_SHIFT];
  assign dquo_next = {div_quo_q[31:0], dq16};

  assign step_d = neg_q ? -$signed(34'(div_quo_q)) : $signed(34'(div_quo_q));
  assign new_w  = 64'(w_q) - 64'(step_d);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = upd_addr;
    ram_wdata = mlpsgd_pkg::sat32(new_w);
    case (state_q)
      S_IDLE: begin
        ram_addr  = AW'(weight_index_i);
        ram_wdata = weight_value_i;
        ram_we    = in_acc && (req_type_i == mlpsgd_pkg::REQ_WRITE) && in_addr_ok;
      end
      S_M_BRD: ram_addr = (kind_q == K_FH) ? hb_addr : ob_addr;
      S_M_RD:  ram_addr = (kind_q == K_FH) ? hw_addr : ow_addr;
      S_U_WR:  ram_we   = 1'b1;
      default: ram_addr = upd_addr;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    feat_cnt_d  = feat_cnt_q;
    label_d     = label_q;
    lr_d        = lr_q;
    clip_d      = clip_q;
    cb_d        = cb_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    w_d         = w_q;
    g_d         = g_q;
    p_d         = p_q;
    neg_d       = neg_q;
    div_num_d   = div_num_q;
    div_rem_d   = div_rem_q;
    div_quo_d   = div_quo_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    feat_we     = 1'b0;
    act_we      = 1'b0;
    score_we    = 1'b0;
    hg_we       = 1'b0;
    store_wdata = feature_value_i;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_acc) begin
      case (cfg_index_i)
        mlpsgd_pkg::CFG_LEARN_RATE: lr_d   = cfg_data_i;
        mlpsgd_pkg::CFG_GRAD_CLIP:  clip_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (req_type_i)
            mlpsgd_pkg::REQ_FEATURE: begin
              feat_we = 1'b1;
              if (feat_cnt_q == I_LAST) begin
                feat_cnt_d = '0;
                kind_d     = K_FH;
                j_d        = '0;
                state_d    = S_M_BRD;
              end else begin
                feat_cnt_d = feat_cnt_q + 1'b1;
              end
            end
            mlpsgd_pkg::REQ_TRAIN: begin
              label_d = label_i;
              state_d = S_T_CB;
            end
            default: ;
          endcase
        end
      end

      // Dot product passes.
      S_M_BRD: begin
        case (kind_q)
          K_FH:    i_d = '0;
          K_FO:    j_d = '0;
          default: k_d = '0;
        endcase
        if (kind_q == K_HG) begin
          acc_d   = '0;
          state_d = S_M_RD;
        end else begin
          state_d = S_M_BINIT;
        end
      end
      S_M_BINIT: begin
        acc_d   = 64'(ram_rd_s);
        state_d = S_M_RD;
      end
      S_M_RD:  state_d = S_M_MUL;
      S_M_MUL: begin
        prod_d  = mul_p;
        state_d = S_M_ACC;
      end
      S_M_ACC: begin
        acc_d   = acc_q + rnd_v;
        state_d = S_M_RD;
        case (kind_q)
          K_FH: begin
            if (i_q == I_LAST) state_d = S_M_END;
            else i_d = i_q + 1'b1;
          end
          K_FO: begin
            if (j_q == J_LAST) state_d = S_M_END;
            else j_d = j_q + 1'b1;
          end
          default: begin
            if (k_q == K_LAST) state_d = S_M_END;
            else k_d = k_q + 1'b1;
          end
        endcase
      end
      S_M_END: begin
        state_d = S_M_BRD;
        case (kind_q)
          K_FH: begin
            act_we      = 1'b1;
            store_wdata = (sat_acc > 0) ? sat_acc : 32'sd0;
            if (j_q == J_LAST) begin
              kind_d = K_FO;
              k_d    = '0;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
          K_FO: begin
            score_we    = 1'b1;
            store_wdata = sat_acc;
            if (k_q == K_LAST) begin
              k_d     = '0;
              state_d = S_EMIT;
            end else begin
              k_d = k_q + 1'b1;
            end
          end
          default: begin
            hg_we       = 1'b1;
            store_wdata = (act_rd > 0) ? sat_acc : 32'sd0;
            if (j_q == J_LAST) begin
              kind_d  = K_HW;
              i_d     = '0;
              j_d     = '0;
              state_d = S_U_RD;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        endcase
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = mlpsgd_pkg::SIDX_W'(k_q);
          out_val_d   = score_rd;
          out_last_d  = (k_q == K_LAST);
          if (k_q == K_LAST) begin
            k_d     = '0;
            state_d = S_IDLE;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end

      // Training step.
      S_T_CB: begin
        div_num_d = 48'({clip_q, 16'd0}) + mlpsgd_pkg::HALF_MILLI;
        div_rem_d = '0;
        div_quo_d = '0;
        div_cnt_d = '0;
        kind_d    = K_CB;
        state_d   = S_DIV;
      end
      S_DIV: begin
        div_rem_d = 10'(dx - 26'(dq16) * mlpsgd_pkg::MILLI);
        div_num_d = {div_num_q[31:0], 16'd0};
        div_quo_d = dquo_next;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == 2'd2) begin
          if (kind_q == K_CB) begin
            cb_d    = 23'(dquo_next);
            kind_d  = K_OW;
            j_d     = '0;
            k_d     = '0;
            state_d = S_U_RD;
          end else begin
            state_d = S_U_WR;
          end
        end
      end
      S_U_RD:  state_d = S_U_MUL;
      S_U_MUL: begin
        prod_d  = mul_p;
        w_d     = ram_rd_s;
        state_d = S_U_CLAMP;
      end
      S_U_CLAMP: begin
        if (rnd_v > cb_s) g_d = 24'(cb_s);
        else if (rnd_v < -cb_s) g_d = 24'(-cb_s);
        else g_d = 24'(rnd_v);
        state_d = S_U_LR;
      end
      S_U_LR: begin
        p_d     = 41'(g_q) * $signed({25'd0, lr_q});
        state_d = S_U_DIVST;
      end
      S_U_DIVST: begin
        neg_d     = p_q[40];
        div_num_d = 48'(p_q[40] ? -p_q : p_q) + mlpsgd_pkg::HALF_MILLI;
        div_rem_d = '0;
        div_quo_d = '0;
        div_cnt_d = '0;
        state_d   = S_DIV;
      end
      S_U_WR: begin
        state_d = S_U_RD;
        case (kind_q)
          K_OW: begin
            if (k_q == K_LAST) begin
              k_d = '0;
              if (j_q == J_LAST) kind_d = K_OB;
              else j_d = j_q + 1'b1;
            end else begin
              k_d = k_q + 1'b1;
            end
          end
          K_OB: begin
            if (k_q == K_LAST) begin
              kind_d  = K_HG;
              j_d     = '0;
              state_d = S_M_BRD;
            end else begin
              k_d = k_q + 1'b1;
            end
          end
          K_HW: begin
            if (j_q == J_LAST) begin
              j_d = '0;
              if (i_q == I_LAST) kind_d = K_HB;
              else i_d = i_q + 1'b1;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
          default: begin
            if (j_q == J_LAST) begin
              j_d     = '0;
              state_d = S_IDLE;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= K_FH;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      feat_cnt_q  <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      lr_q        <= mlpsgd_pkg::LR_RESET;
      clip_q      <= mlpsgd_pkg::CLIP_RESET;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      feat_cnt_q  <= feat_cnt_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
      lr_q        <= lr_d;
      clip_q      <= clip_d;
    end
  end

  // Datapath registers and neuron stores carry no reset.
  always_ff @(posedge clk_i) begin
    label_q   <= label_d;
    cb_q      <= cb_d;
    acc_q     <= acc_d;
    prod_q    <= prod_d;
    w_q       <= w_d;
    g_q       <= g_d;
    p_q       <= p_d;
    neg_q     <= neg_d;
    div_num_q <= div_num_d;
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    out_idx_q <= out_idx_d;
    out_val_q <= out_val_d;
    out_last_q <= out_last_d;
    if (feat_we)  feat_q[feat_cnt_q] <= store_wdata;
    if (act_we)   act_q[j_q]         <= store_wdata;
    if (score_we) score_q[k_q]       <= store_wdata;
    if (hg_we)    hg_q[j_q]          <= store_wdata;
  end

  mlpsgd_ram #(
    .WIDTH (32),
    .DEPTH (mlpsgd_pkg::ADDR_END)
  ) u_param_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  // The divide remainder must stay a valid residue or the quotient digits are wrong.
  a_div_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_rem_q < 10'd1000))
    else $error("divider remainder out of range");

  // Only a weight write transaction or the update write may touch the parameter RAM.
  a_ram_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == S_IDLE && in_acc) || state_q == S_U_WR))
    else $error("unexpected parameter RAM write");

  // A forward pass always starts with the feature count wrapped to zero.
  a_feat_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && state_d == S_M_BRD) |=> (feat_cnt_q == '0))
    else $error("feature count not cleared at forward start");

  // A score is loaded into the output register only while emitting.
  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && out_valid_d) |-> (state_q == S_EMIT))
    else $error("score loaded outside the emit phase");
`endif

endmodule
